/* rtl/core/crcc_pkg.sv */
package crcc_pkg;

    // Record layout and read granularity
    localparam int BLOCK_BYTES  = 4096;
    localparam int HEADER_BYTES = 24;
    localparam int MAGIC_POS    = 0;
    localparam int CRC_POS      = 8;

    // Byte counter width; the counter saturates at its maximum
    localparam int POS_W = 17;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // CRC-32C, reflected form
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

    // Result queue depth; one request can push two results
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Status codes
    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_IO_ERROR  = 3'd1;
    localparam logic [2:0] STATUS_BAD_MAGIC = 3'd2;
    localparam logic [2:0] STATUS_CRC_BAD   = 3'd3;
    localparam logic [2:0] STATUS_TRUNCATED = 3'd4;

    // Input request payload
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [11:0] hdr_offset;
        logic [15:0] payload_length;
        logic [7:0]  io_code;
    } in_item_t;

    // Result payload
    typedef struct packed {
        logic       is_status;
        logic [7:0] payload_out;
        logic [2:0] status_code;
        logic [7:0] error_number;
        logic       end_of_run;
    } out_item_t;

    // Results produced for one input request, in order
    typedef struct packed {
        logic [1:0] count;
        out_item_t  item0;
        out_item_t  item1;
    } push_t;

    // One byte folded into the reflected CRC register
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

/* rtl/core/crcc_track.sv */
module crcc_track (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  crcc_pkg::in_item_t item,
    input  logic [31:0]        magic_word,
    output crcc_pkg::push_t    push
);

    logic [crcc_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [11:0] hs_reg, hs_next;
    logic [15:0] len_reg, len_next;
    logic [31:0] magic_reg, magic_next;
    logic [31:0] crcs_reg, crcs_next;
    logic [31:0] crc_reg, crc_next;
    logic [7:0]  err_reg, err_next;
    logic        inbuf_reg, inbuf_next;

    logic                        first;
    logic                        active;
    logic [crcc_pkg::POS_W-1:0]  pos;
    logic [11:0]                 hs;
    logic [15:0]                 len;
    logic [7:0]                  err;
    logic [31:0]                 magic_base, crcs_base, crc_base;
    logic                        after_hdr;
    logic [crcc_pkg::POS_W-1:0]  rel;
    logic [crcc_pkg::POS_W-1:0]  rel_pay;
    logic                        in_payload;
    logic                        fwd;
    logic [17:0]                 need;
    logic                        trunc;
    logic [2:0]                  code;
    crcc_pkg::out_item_t         pay_item, stat_item;

    // Start-of-buffer values override the held state
    always_comb
    begin
        first      = item.first_byte;
        active     = first || inbuf_reg;
        pos        = first ? '0 : pos_reg;
        hs         = first ? item.hdr_offset : hs_reg;
        len        = first ? item.payload_length : len_reg;
        err        = first ? item.io_code : err_reg;
        magic_base = first ? '0 : magic_reg;
        crcs_base  = first ? '0 : crcs_reg;
        crc_base   = first ? crcc_pkg::CRC_INIT : crc_reg;
        after_hdr  = pos >= {5'd0, hs};
        rel        = pos - {5'd0, hs};
    end

    // Header word capture, little-endian byte lanes
    always_comb
    begin
        magic_next = magic_base;
        crcs_next  = crcs_base;
        for (int k = 0; k < 4; k++)
        begin
            if (after_hdr && rel == crcc_pkg::POS_W'(crcc_pkg::MAGIC_POS + k))
            begin
                magic_next[8*k +: 8] = magic_base[8*k +: 8] | item.data_byte;
            end
            if (after_hdr && rel == crcc_pkg::POS_W'(crcc_pkg::CRC_POS + k))
            begin
                crcs_next[8*k +: 8] = crcs_base[8*k +: 8] | item.data_byte;
            end
        end
    end

    // Payload window and CRC update
    always_comb
    begin
        rel_pay    = rel - crcc_pkg::POS_W'(crcc_pkg::HEADER_BYTES);
        in_payload = after_hdr && (rel >= crcc_pkg::POS_W'(crcc_pkg::HEADER_BYTES))
                     && (rel_pay < {1'b0, len});
        crc_next   = in_payload ? crcc_pkg::crc_byte(crc_base, item.data_byte) : crc_base;
        fwd        = in_payload && (err == 8'd0);
    end

    // Final status with its priority order
    always_comb
    begin
        need  = 18'(hs) + 18'(crcc_pkg::HEADER_BYTES) + 18'(len);
        trunc = (18'(pos) + 18'd1) < need;
        if (err != 8'd0)
        begin
            code = crcc_pkg::STATUS_IO_ERROR;
        end
        else if (trunc)
        begin
            code = crcc_pkg::STATUS_TRUNCATED;
        end
        else if (magic_next != magic_word)
        begin
            code = crcc_pkg::STATUS_BAD_MAGIC;
        end
        else if ((crc_next ^ crcc_pkg::CRC_INIT) != crcs_next)
        begin
            code = crcc_pkg::STATUS_CRC_BAD;
        end
        else
        begin
            code = crcc_pkg::STATUS_OK;
        end
    end

    // Result items for this request
    always_comb
    begin
        pay_item.is_status    = 1'b0;
        pay_item.payload_out  = item.data_byte;
        pay_item.status_code  = crcc_pkg::STATUS_OK;
        pay_item.error_number = 8'd0;
        pay_item.end_of_run   = !item.last_byte;

        stat_item.is_status    = 1'b1;
        stat_item.payload_out  = 8'd0;
        stat_item.status_code  = code;
        stat_item.error_number = (code == crcc_pkg::STATUS_IO_ERROR) ? err : 8'd0;
        stat_item.end_of_run   = 1'b1;

        push.item1 = stat_item;
        if (!fire || !active)
        begin
            push.count = 2'd0;
            push.item0 = stat_item;
        end
        else if (fwd)
        begin
            push.count = item.last_byte ? 2'd2 : 2'd1;
            push.item0 = pay_item;
        end
        else
        begin
            push.count = item.last_byte ? 2'd1 : 2'd0;
            push.item0 = stat_item;
        end
    end

    // Next state
    always_comb
    begin
        pos_next   = (pos < crcc_pkg::POS_MAX) ? pos + 1'b1 : pos;
        hs_next    = hs;
        len_next   = len;
        err_next   = err;
        inbuf_next = !item.last_byte;
    end

    // Buffer state; a byte outside a buffer leaves it untouched
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            hs_reg    <= '0;
            len_reg   <= '0;
            magic_reg <= '0;
            crcs_reg  <= '0;
            crc_reg   <= crcc_pkg::CRC_INIT;
            err_reg   <= '0;
            inbuf_reg <= 1'b0;
        end
        else if (fire && active)
        begin
            pos_reg   <= pos_next;
            hs_reg    <= hs_next;
            len_reg   <= len_next;
            magic_reg <= magic_next;
            crcs_reg  <= crcs_next;
            crc_reg   <= crc_next;
            err_reg   <= err_next;
            inbuf_reg <= inbuf_next;
        end
    end

endmodule

/* rtl/core/crcc_out_queue.sv */
module crcc_out_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  crcc_pkg::push_t     push,
    output logic                space,
    output logic                out_valid,
    input  logic                out_ready,
    output crcc_pkg::out_item_t out_data
);

    crcc_pkg::out_item_t mem_reg [crcc_pkg::QUEUE_DEPTH];

    logic [crcc_pkg::QPTR_W-1:0] head_reg, head_next;
    logic [crcc_pkg::QPTR_W-1:0] tail_reg, tail_next;
    logic [crcc_pkg::QCNT_W-1:0] count_reg, count_next;
    logic [crcc_pkg::QPTR_W-1:0] tail_plus1;
    logic                        pop;

    // Room for the two results one request can bring
    assign space     = count_reg <= crcc_pkg::QCNT_W'(crcc_pkg::QUEUE_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[head_reg];
    assign pop       = out_valid && out_ready;

    // Pointer and fill count updates
    always_comb
    begin
        tail_plus1 = tail_reg + 1'b1;
        head_next  = pop ? head_reg + 1'b1 : head_reg;
        tail_next  = tail_reg + crcc_pkg::QPTR_W'(push.count);
        count_next = count_reg + crcc_pkg::QCNT_W'(push.count)
                     - crcc_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Storage writes at the tail
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[tail_reg] <= push.item0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[tail_plus1] <= push.item1;
        end
    end

endmodule

/* rtl/core/crc32c_record_checker_core.sv */
// Channel   Direction  Payload              Transfer
// in        input      crcc_pkg::in_item_t  in_valid & in_ready
// out       output     crcc_pkg::out_item_t out_valid & out_ready
// cfg       input      32-bit magic word    cfg_valid & cfg_ready (always ready)
//
// One byte request is taken per cycle while the result queue has room; results pass
// through an input register and a four-entry result queue.
// A last byte inside the payload with no I/O error gives two results.
// The input side stalls only when the result queue has fewer than two free slots.
// Reset clears all buffer state and the queue; the CRC register resets to all ones.
module crc32c_record_checker_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  crcc_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output crcc_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [31:0]         cfg_data
);

    crcc_pkg::in_item_t item_reg;
    logic               item_valid_reg;
    logic [31:0]        magic_reg;
    logic               space;
    logic               fire;
    crcc_pkg::push_t    push;

    // Input register advances when the queue can take its results
    assign fire      = item_valid_reg && space;
    assign in_ready  = !item_valid_reg || space;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_data;
        end
    end

    // Expected magic register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            magic_reg <= cfg_data;
        end
    end

    crcc_track u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (item_reg),
        .magic_word (magic_reg),
        .push       (push)
    );

    crcc_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
